// File: design/rfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants of the RPC frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

  // Frame layout
  localparam int LEN_BYTES  = 4;
  localparam int ID_BYTES   = 8;
  localparam int HEADER_LEN = LEN_BYTES + ID_BYTES;
  localparam int MIN_NAME   = 3;
  localparam logic [7:0] COLON_CHAR = 8'h3a;

  // Width of counts and lengths (lengths stay below 2^31)
  localparam int CNT_W = 31;

  // Configuration reset values
  localparam logic [CNT_W-1:0] MIN_FRAME_RST = 31'd12;
  localparam logic [CNT_W-1:0] MAX_FRAME_RST = 31'd67108864;

  // Configuration register indexes
  typedef enum logic {
    REG_MIN_FRAME = 1'b0,
    REG_MAX_FRAME = 1'b1
  } reg_idx_t;

  // Parser phase
  typedef enum logic [2:0] {
    PH_LEN,
    PH_ID,
    PH_NLEN,
    PH_NAME,
    PH_PAY,
    PH_DROP
  } phase_t;

  // Output segment tags
  typedef enum logic [1:0] {
    SEG_SERVICE = 2'd0,
    SEG_METHOD  = 2'd1,
    SEG_PAYLOAD = 2'd2,
    SEG_STATUS  = 2'd3
  } seg_t;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_NAME   = 2'd2
  } err_t;

  // One result beat
  typedef struct packed {
    seg_t              seg;
    logic [7:0]        data;
    logic              frame_end;
    err_t              err;
    logic              is_resp;
    logic [62:0]       req_id;
    logic [CNT_W-1:0]  pay_len;
  } res_t;

endpackage

// File: design/rpc_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_frame_deframer
// Splits a byte stream of length-prefixed RPC frames into tagged
// service, method and payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one stream byte per beat (valid/ready).
//   out_* : at most one result beat per input byte: a service, method or
//           payload byte, or a status beat (segment 3) carrying an error or
//           the end of a frame with an empty payload. Non-error beats carry the
//           frame id, response flag and payload length.
//   cfg_* : write port for the min/max frame length limits; always ready.
//           Write only while no beat is in flight.
// Output: each result is registered on out_*, or in the skid register.
// Throughput: one byte per cycle while in_ready is high; the parser updates
//   all state in the accepting cycle, so its per-byte step sets the rate.
// Stall: an output register plus a one-entry skid register hold results;
//   in_ready drops only when both are full.
// Reset: parser returns to the length field, limits go to 12 and 2^26,
//   output beats are dropped. A bad frame length halts parsing (bytes are
//   still taken, with no result) until the next reset.
// ----------------------------------------------------------------------------
module rpc_frame_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  // result stream
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_segment,
  output logic [7:0]                     out_data,
  output logic                           out_frame_end,
  output logic [1:0]                     out_error_code,
  output logic                           out_is_response,
  output logic [62:0]                    out_request_id,
  output logic [30:0]                    out_payload_length,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  rfd_pkg::reg_idx_t              cfg_index,
  input  logic [rfd_pkg::CNT_W-1:0]      cfg_data
);
  import rfd_pkg::*;

  // Parser state
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [23:0]        fl_r, fl_nxt;
  logic [CNT_W-1:0]   body_r, body_nxt;
  logic [63:0]        id_r, id_nxt;
  logic [23:0]        nl_r, nl_nxt;
  logic [CNT_W-1:0]   pay_r, pay_nxt;
  logic               colon_r, colon_nxt;
  logic               halted_r, halted_nxt;

  // Limits
  logic [CNT_W-1:0]   min_r, min_nxt;
  logic [CNT_W-1:0]   max_r, max_nxt;

  // Output and skid registers
  res_t               out_r, out_nxt;
  logic               out_vld_r, out_vld_nxt;
  res_t               skid_r, skid_nxt;
  logic               skid_vld_r, skid_vld_nxt;

  // Per-byte working signals
  logic               in_fire, out_fire, cfg_fire;
  logic [31:0]        fl_new, nl_new;
  logic [31:0]        nl_diff;
  logic               len_bad, nl_bad, last;
  logic [CNT_W-1:0]   cnt_dec, cnt_inc;
  res_t               res;
  logic               res_vld;

  assign in_ready  = !skid_vld_r;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_vld_r && out_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Field assembly and checks
  assign fl_new  = {fl_r, in_data_byte};
  assign nl_new  = {nl_r, in_data_byte};
  assign nl_diff = {1'b0, body_r} - {1'b0, nl_new[CNT_W-1:0]};
  assign len_bad = fl_new[31] || (fl_new[CNT_W-1:0] > max_r) ||
                   (fl_new[CNT_W-1:0] < min_r);
  assign nl_bad  = nl_new[31] || (nl_new[CNT_W-1:0] < CNT_W'(MIN_NAME)) || nl_diff[31];
  assign last    = (cnt_r == CNT_W'(1));
  assign cnt_dec = cnt_r - CNT_W'(1);
  assign cnt_inc = cnt_r + CNT_W'(1);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEN;
      cnt_r      <= '0;
      colon_r    <= 1'b0;
      halted_r   <= 1'b0;
      min_r      <= MIN_FRAME_RST;
      max_r      <= MAX_FRAME_RST;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      colon_r    <= colon_nxt;
      halted_r   <= halted_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fl_r   <= fl_nxt;
    body_r <= body_nxt;
    id_r   <= id_nxt;
    nl_r   <= nl_nxt;
    pay_r  <= pay_nxt;
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // Configuration writes
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (cfg_fire) begin
      case (cfg_index)
        REG_MIN_FRAME: min_nxt = cfg_data;
        REG_MAX_FRAME: max_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Next state and result of the accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    fl_nxt     = fl_r;
    body_nxt   = body_r;
    id_nxt     = id_r;
    nl_nxt     = nl_r;
    pay_nxt    = pay_r;
    colon_nxt  = colon_r;
    halted_nxt = halted_r;

    res_vld       = 1'b0;
    res.seg       = SEG_STATUS;
    res.data      = '0;
    res.frame_end = 1'b0;
    res.err       = ERR_NONE;
    res.is_resp   = id_r[63];
    res.req_id    = id_r[62:0];
    res.pay_len   = pay_r;

    if (in_fire && !halted_r) begin
      case (phase_r)
        // Big-endian frame length
        PH_LEN: begin
          fl_nxt  = fl_new[23:0];
          cnt_nxt = cnt_inc;
          if (cnt_r == CNT_W'(LEN_BYTES - 1)) begin
            cnt_nxt  = '0;
            body_nxt = fl_new[CNT_W-1:0] - CNT_W'(HEADER_LEN);
            if (len_bad) begin
              halted_nxt    = 1'b1;
              res_vld       = 1'b1;
              res.frame_end = 1'b1;
              res.err       = ERR_LENGTH;
              res.is_resp   = 1'b0;
              res.req_id    = '0;
              res.pay_len   = '0;
            end else if (fl_new[CNT_W-1:0] < CNT_W'(HEADER_LEN)) begin
              // short frame: drop its bytes
              cnt_nxt       = fl_new[CNT_W-1:0];
              phase_nxt     = (fl_new[CNT_W-1:0] == '0) ? PH_LEN : PH_DROP;
              res_vld       = 1'b1;
              res.frame_end = 1'b1;
              res.err       = ERR_NAME;
              res.is_resp   = 1'b0;
              res.req_id    = '0;
              res.pay_len   = '0;
            end else begin
              phase_nxt = PH_ID;
            end
          end
        end

        // Frame id
        PH_ID: begin
          id_nxt  = {id_r[55:0], in_data_byte};
          cnt_nxt = cnt_inc;
          if (cnt_r == CNT_W'(ID_BYTES - 1)) begin
            cnt_nxt   = '0;
            phase_nxt = PH_NLEN;
          end
        end

        // Name length, checked against the body size
        PH_NLEN: begin
          nl_nxt  = nl_new[23:0];
          cnt_nxt = cnt_inc;
          if (cnt_r == CNT_W'(LEN_BYTES - 1)) begin
            colon_nxt = 1'b0;
            if (nl_bad) begin
              cnt_nxt       = body_r;
              phase_nxt     = (body_r == '0) ? PH_LEN : PH_DROP;
              res_vld       = 1'b1;
              res.frame_end = 1'b1;
              res.err       = ERR_NAME;
              res.pay_len   = '0;
            end else begin
              cnt_nxt   = nl_new[CNT_W-1:0];
              pay_nxt   = nl_diff[CNT_W-1:0];
              phase_nxt = PH_NAME;
            end
          end
        end

        // Name bytes; cnt_r holds bytes left
        PH_NAME: begin
          cnt_nxt = cnt_dec;
          if (!colon_r && in_data_byte == COLON_CHAR) begin
            colon_nxt = 1'b1;
            if (last) begin
              if (pay_r != '0) begin
                cnt_nxt   = pay_r;
                phase_nxt = PH_PAY;
              end else begin
                cnt_nxt       = '0;
                phase_nxt     = PH_LEN;
                res_vld       = 1'b1;
                res.frame_end = 1'b1;
              end
            end
          end else if (!colon_r) begin
            res_vld = 1'b1;
            if (last) begin
              // no colon in the name
              cnt_nxt       = pay_r;
              phase_nxt     = (pay_r == '0) ? PH_LEN : PH_DROP;
              res.frame_end = 1'b1;
              res.err       = ERR_NAME;
              res.pay_len   = '0;
            end else begin
              res.seg  = SEG_SERVICE;
              res.data = in_data_byte;
            end
          end else begin
            res_vld       = 1'b1;
            res.seg       = SEG_METHOD;
            res.data      = in_data_byte;
            res.frame_end = last && (pay_r == '0);
            if (last) begin
              cnt_nxt   = (pay_r != '0) ? pay_r : '0;
              phase_nxt = (pay_r != '0) ? PH_PAY : PH_LEN;
            end
          end
        end

        // Payload bytes; cnt_r holds bytes left
        PH_PAY: begin
          res_vld       = 1'b1;
          res.seg       = SEG_PAYLOAD;
          res.data      = in_data_byte;
          res.frame_end = last;
          cnt_nxt       = last ? '0 : cnt_dec;
          if (last) begin
            phase_nxt = PH_LEN;
          end
        end

        // Discard rest of a bad frame
        PH_DROP: begin
          cnt_nxt = cnt_dec;
          if (last) begin
            phase_nxt = PH_LEN;
          end
        end

        default: begin
          phase_nxt = PH_LEN;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  // Output register with skid entry
  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (out_fire) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (res_vld) begin
      if (!out_vld_r || out_ready) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = res;
        skid_vld_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_vld_nxt = 1'b0;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_segment        = out_r.seg;
  assign out_data           = out_r.data;
  assign out_frame_end      = out_r.frame_end;
  assign out_error_code     = out_r.err;
  assign out_is_response    = out_r.is_resp;
  assign out_request_id     = out_r.req_id;
  assign out_payload_length = out_r.pay_len;

endmodule

// File: design/rfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_checker
// Port-level checks on the RPC frame deframer's result stream.
// ----------------------------------------------------------------------------
module rfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_segment,
  input logic [7:0]  out_data,
  input logic        out_frame_end,
  input logic [1:0]  out_error_code,
  input logic [62:0] out_request_id,
  input logic [30:0] out_payload_length
);
  import rfd_pkg::*;

  // Stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) &&
      $stable(out_segment) && $stable(out_error_code))
    else $error("result beat changed while stalled");

  // Every error beat closes its frame
  a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_frame_end)
    else $error("error beat without frame end");

  // Length errors are bare status beats
  a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == ERR_LENGTH |->
      out_segment == SEG_STATUS && out_request_id == '0 && out_payload_length == '0)
    else $error("length error beat carries data");

  // Data beats never carry an error
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_segment != SEG_STATUS |-> out_error_code == ERR_NONE)
    else $error("data beat flagged with error");

  // Input backpressure only with a full output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind rpc_frame_deframer rfd_checker u_rfd_checker (.*);

// File: bench/rpc_frame_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_frame_deframer_test
// Self-checking bench for the RPC frame deframer. Frames are sent byte by byte
// in bursts while the result side stalls on its own pattern. Each accepted
// byte is run through a local parser model, and every result beat is checked
// field by field against the oldest predicted beat. Covers well-formed
// frames, name errors, short frames, several length limit settings, and
// finally a bad length that halts the parser for the rest of the run.
// ----------------------------------------------------------------------------
module rpc_frame_deframer_test;
  import rfd_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef logic [7:0] byte_q_t[$];
  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;
  typedef enum {HALT_TOP_BIT, HALT_ABOVE_MAX, HALT_BELOW_MIN, HALT_CROSSED} halt_kind_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_data_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_segment;
  logic [7:0]        out_data;
  logic              out_frame_end;
  logic [1:0]        out_error_code;
  logic              out_is_response;
  logic [62:0]       out_request_id;
  logic [30:0]       out_payload_length;
  logic              cfg_valid;
  logic              cfg_ready;
  reg_idx_t          cfg_index;
  logic [CNT_W-1:0]  cfg_data;

  rpc_frame_deframer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser model state
  phase_t            parse_phase = PH_LEN;
  logic [31:0]       field_bytes = '0;
  logic [31:0]       cur_len = '0;
  logic [63:0]       cur_id = '0;
  logic [31:0]       cur_name_len = '0;
  bit                colon_found = 1'b0;
  bit                parser_dead = 1'b0;
  logic [CNT_W-1:0]  lim_min = MIN_FRAME_RST;
  logic [CNT_W-1:0]  lim_max = MAX_FRAME_RST;

  res_t              pending_beats[$];
  int                fail_count = 0;
  int                bytes_sent = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic void queue_beat(seg_t s, logic [7:0] d, logic fe, err_t e,
                                     bit with_id, logic [31:0] pay);
    res_t r;
    r.seg       = s;
    r.data      = d;
    r.frame_end = fe;
    r.err       = e;
    r.is_resp   = with_id ? cur_id[63] : 1'b0;
    r.req_id    = with_id ? cur_id[62:0] : '0;
    r.pay_len   = pay[30:0];
    pending_beats.push_back(r);
  endfunction

  // after a name error, skip the rest of the frame
  function automatic void skip_bytes(logic [31:0] remaining);
    field_bytes = remaining;
    parse_phase = (remaining == 0) ? PH_LEN : PH_DROP;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [31:0] body;
    logic [31:0] pay;
    bit          last;
    if (parser_dead) return;
    case (parse_phase)
      PH_LEN: begin
        cur_len = {cur_len[23:0], b};
        field_bytes++;
        if (field_bytes < LEN_BYTES) return;
        field_bytes  = '0;
        cur_id       = '0;
        cur_name_len = '0;
        colon_found  = 1'b0;
        if (cur_len[31] || cur_len > lim_max || cur_len < lim_min) begin
          parser_dead = 1'b1;
          queue_beat(SEG_STATUS, 8'h00, 1'b1, ERR_LENGTH, 1'b0, 0);
        end else if (cur_len < HEADER_LEN) begin
          skip_bytes(cur_len);
          queue_beat(SEG_STATUS, 8'h00, 1'b1, ERR_NAME, 1'b0, 0);
        end else begin
          parse_phase = PH_ID;
        end
      end
      PH_ID: begin
        cur_id = {cur_id[55:0], b};
        field_bytes++;
        if (field_bytes >= ID_BYTES) begin
          field_bytes = 0;
          parse_phase = PH_NLEN;
        end
      end
      PH_NLEN: begin
        cur_name_len = {cur_name_len[23:0], b};
        field_bytes++;
        if (field_bytes < LEN_BYTES) return;
        field_bytes = 0;
        body = cur_len - HEADER_LEN;
        if (cur_name_len[31] || cur_name_len < MIN_NAME || cur_name_len > body) begin
          skip_bytes(body);
          queue_beat(SEG_STATUS, 8'h00, 1'b1, ERR_NAME, 1'b1, 0);
        end else begin
          parse_phase = PH_NAME;
        end
      end
      PH_NAME: begin
        field_bytes++;
        last = (field_bytes >= cur_name_len);
        pay  = cur_len - HEADER_LEN - cur_name_len;
        if (!colon_found && b == COLON_CHAR) begin
          // first colon splits service from method
          colon_found = 1'b1;
          if (!last) return;
          field_bytes = 0;
          if (pay != 0) begin
            parse_phase = PH_PAY;
            return;
          end
          parse_phase = PH_LEN;
          queue_beat(SEG_STATUS, 8'h00, 1'b1, ERR_NONE, 1'b1, pay);
        end else if (!colon_found) begin
          if (last) begin
            // name ended without a colon
            skip_bytes(pay);
            queue_beat(SEG_STATUS, 8'h00, 1'b1, ERR_NAME, 1'b1, 0);
          end else begin
            queue_beat(SEG_SERVICE, b, 1'b0, ERR_NONE, 1'b1, pay);
          end
        end else begin
          if (last) begin
            field_bytes = 0;
            parse_phase = (pay != 0) ? PH_PAY : PH_LEN;
          end
          queue_beat(SEG_METHOD, b, last && pay == 0, ERR_NONE, 1'b1, pay);
        end
      end
      PH_PAY: begin
        pay = cur_len - HEADER_LEN - cur_name_len;
        field_bytes++;
        last = (field_bytes >= pay);
        if (last) begin
          field_bytes = 0;
          parse_phase = PH_LEN;
        end
        queue_beat(SEG_PAYLOAD, b, last, ERR_NONE, 1'b1, pay);
      end
      PH_DROP: begin
        if (field_bytes > 0) field_bytes--;
        if (field_bytes == 0) parse_phase = PH_LEN;
      end
      default: begin
        parse_phase = PH_LEN;
        field_bytes = 0;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Prediction and checking at each rising edge
  // --------------------------------------------------------------------------
  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : beat_check
    res_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_FRAME: lim_min = cfg_data;
          REG_MAX_FRAME: lim_max = cfg_data;
          default: ;
        endcase
      end
      // predict first: a result never leaves before its byte
      if (in_valid && in_ready) deframe_byte(in_data_byte);
      if (out_valid && out_ready) begin
        if (pending_beats.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual segment %0d data %0h",
                   $time, out_segment, out_data);
          fail_count++;
        end else begin
          want = pending_beats.pop_front();
          check_field("segment", 64'(want.seg), 64'(out_segment));
          check_field("data", 64'(want.data), 64'(out_data));
          check_field("frame_end", 64'(want.frame_end), 64'(out_frame_end));
          check_field("error_code", 64'(want.err), 64'(out_error_code));
          check_field("is_response", 64'(want.is_resp), 64'(out_is_response));
          check_field("request_id", 64'(want.req_id), 64'(out_request_id));
          check_field("payload_length", 64'(want.pay_len), 64'(out_payload_length));
        end
      end
    end
  end

  // Watchdog: cycles in a row with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_beats.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Result side back-pressure, switching between stall patterns
  initial begin : rx_stall
    rx_mode_t mode;
    int       span;
    int       rx_tick;
    rx_tick   = 0;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(negedge clk);
        rx_tick++;
        case (mode)
          RX_OPEN:  out_ready <= 1'b1;
          RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
          default:  out_ready <= (rx_tick % 4 == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // one stream byte; bursts of random length with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_filler(input int n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // header, given name bytes, then random bytes up to the frame length
  task automatic send_frame(input logic [31:0] len_v, input logic [63:0] id_v,
                            input logic [31:0] nlen_v, input byte_q_t nm);
    send_word(len_v);
    for (int i = 7; i >= 0; i--) send_byte(id_v[8*i +: 8]);
    send_word(nlen_v);
    foreach (nm[i]) send_byte(nm[i]);
    send_filler(int'(len_v) - HEADER_LEN - nm.size());
  endtask

  function automatic byte_q_t text_bytes(input string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [63:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] r;
    do r = 8'($urandom); while (r == COLON_CHAR);
    return r;
  endfunction

  // input idle, all results in, then a drain wait for the pipeline
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input logic [CNT_W-1:0] lo, input logic [CNT_W-1:0] hi);
    wait_idle();
    write_reg(REG_MIN_FRAME, lo);
    write_reg(REG_MAX_FRAME, hi);
  endtask

  // one random frame whose length fits [lo, hi]; mostly well formed
  task automatic random_frame(input int lo, input int hi);
    byte_q_t     nm;
    logic [31:0] len_v;
    logic [31:0] nlen_v;
    int          lmin, lmax, body, name_n, svc, pick, fault;
    lmin = (lo > HEADER_LEN + MIN_NAME) ? lo : HEADER_LEN + MIN_NAME;
    lmax = (hi < HEADER_LEN + 30) ? hi : HEADER_LEN + 30;
    pick = $urandom_range(0, 99);
    if (pick < 8 && lo < HEADER_LEN) begin
      // too short to hold a header
      len_v = $urandom_range(lo, (hi < HEADER_LEN) ? hi : HEADER_LEN - 1);
      send_word(len_v);
      send_filler(len_v);
    end else if (pick < 20) begin
      // broken name length
      len_v = $urandom_range((lo > HEADER_LEN) ? lo : HEADER_LEN, lmax);
      body  = len_v - HEADER_LEN;
      fault = $urandom_range(0, 3);
      if (fault == 0)      nlen_v = $urandom_range(0, MIN_NAME - 1);
      else if (fault == 1) nlen_v = body + $urandom_range(1, 4);
      else if (fault == 2) nlen_v = {1'b1, 31'($urandom)};
      else                 nlen_v = 32'h7fff_ffff;
      send_frame(len_v, rand_id(), nlen_v, nm);
    end else begin
      len_v  = $urandom_range(lmin, lmax);
      body   = len_v - HEADER_LEN;
      name_n = $urandom_range(MIN_NAME, (body < 10) ? body : 10);
      // name filling the whole body, so no payload follows
      if (pick >= 88 && body <= 16) name_n = body;
      if (pick < 30) begin
        repeat (name_n) nm.push_back(plain_byte());
      end else begin
        svc = (pick >= 88) ? name_n - 1 : $urandom_range(0, name_n - 1);
        repeat (svc) nm.push_back(plain_byte());
        nm.push_back(COLON_CHAR);
        repeat (name_n - 1 - svc)
          nm.push_back(($urandom_range(0, 5) == 0) ? COLON_CHAR : 8'($urandom));
      end
      send_frame(len_v, rand_id(), name_n, nm);
    end
  endtask

  task automatic run_random(input int lo, input int hi, input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) random_frame(lo, hi);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_frame_cases();
    byte_q_t nm;
    // extreme bytes around the colon, response id of all ones
    nm = text_bytes("a:b");
    nm[0] = 8'h00;
    nm[2] = 8'hff;
    send_frame(32'd17, '1, 32'd3, nm);
    send_frame(32'd15, 64'd0, 32'd3, text_bytes("ab:"));     // colon last, no payload
    send_frame(32'd16, 64'h0123_4567_89ab_cdef, 32'd3, text_bytes("xy:"));
    send_frame(32'd15, rand_id(), 32'd3, text_bytes(":m:")); // later colon is method
    send_frame(32'd17, rand_id(), 32'd3, text_bytes("abc")); // no colon, payload dropped
    send_frame(32'd15, rand_id(), 32'd3, text_bytes("xyz")); // no colon, nothing to drop
    nm.delete();
    send_frame(32'd14, rand_id(), 32'd2, nm);                // name too short
    send_frame(32'd14, rand_id(), 32'd5, nm);                // name beyond the body
    send_frame(32'd16, rand_id(), 32'h8000_0003, nm);        // name length top bit
    send_frame(32'd12, rand_id(), 32'd0, nm);                // header only
    wait_idle();
  endtask

  task automatic test_random_default();
    run_random(int'(MIN_FRAME_RST), int'(MAX_FRAME_RST), 200);
    // hold off until everything is out, then go on
    wait_idle();
    run_random(int'(MIN_FRAME_RST), int'(MAX_FRAME_RST), 200);
  endtask

  task automatic test_wide_limits();
    set_limits('0, '1);
    send_word(32'd0);                 // empty frame
    send_word(32'd11);                // one byte short of a header
    send_filler(11);
    send_word(32'd1);
    send_filler(1);
    run_random(0, 32'h7fff_ffff, 400);
  endtask

  task automatic test_tight_limits();
    set_limits(31'd20, 31'd40);
    send_frame(32'd20, rand_id(), 32'd3, text_bytes("s:m"));
    send_frame(32'd40, rand_id(), 32'd3, text_bytes("s:m"));
    run_random(20, 40, 200);
    set_limits(31'd24, 31'd24);
    run_random(24, 24, 100);
  endtask

  // bad length halts the parser; everything after it is ignored
  task automatic test_length_halt();
    halt_kind_t kind;
    kind = halt_kind_t'($urandom_range(0, 3));
    case (kind)
      HALT_CROSSED: set_limits('1, '0);
      HALT_TOP_BIT: set_limits(31'd12, '1);
      default:      set_limits(31'd12, 31'd100);
    endcase
    case (kind)
      HALT_TOP_BIT:   send_word({1'b1, 31'($urandom)});
      HALT_ABOVE_MAX: send_word($urandom_range(101, 200));
      HALT_BELOW_MIN: send_word($urandom_range(0, 11));
      default:        send_word(32'd20);
    endcase
    send_frame(32'd17, rand_id(), 32'd3, text_bytes("a:b"));
    send_filler(30);
  endtask

  initial begin
    in_valid     = 1'b0;
    in_data_byte = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_MIN_FRAME;
    cfg_data     = '0;
    rst_n        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_frame_cases();
    test_random_default();
    test_wide_limits();
    test_tight_limits();
    test_length_halt();

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
design/rfd_pkg.sv
design/rpc_frame_deframer.sv
design/rfd_checker.sv
bench/rpc_frame_deframer_test.sv
